// File: rtl/usfp_pkg.sv
// ----------------------------------------------------------------------------
// usfp_pkg - shared types and constants
// Phase codes, opcode and flash command bytes, and the result word layout
// for the UART-driven SPI flash programmer.
// ----------------------------------------------------------------------------
package usfp_pkg;

  // command frame length, in UART bytes
  localparam int unsigned FrameBytes = 8;
  localparam int unsigned FrameIdxW  = $clog2(FrameBytes);

  // UART opcodes (ASCII)
  localparam logic [7:0] OP_READ    = 8'd114; // 'r'
  localparam logic [7:0] OP_ERASE   = 8'd101; // 'e'
  localparam logic [7:0] OP_PROGRAM = 8'd119; // 'w'
  localparam logic [7:0] OP_FILL    = 8'd98;  // 'b'
  localparam logic [7:0] OP_DONE    = 8'd100; // 'd'

  // UART completion answer
  localparam logic [7:0] ANS_READY  = 8'd114; // 'r'

  // flash command bytes
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_ERASE  = 8'h52;
  localparam logic [7:0] CMD_PROG   = 8'h02;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_RDSR   = 8'h05;
  localparam logic [7:0] CMD_DUMMY  = 8'h00;

  // status register bits
  localparam int unsigned SR_BUSY = 0;
  localparam int unsigned SR_WEL  = 1;

  // result destinations
  localparam logic DEST_SPI  = 1'b0;
  localparam logic DEST_UART = 1'b1;

  // input kinds
  localparam logic KIND_UART = 1'b0;
  localparam logic KIND_SPI  = 1'b1;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0000000000001,
    PH_FILL    = 13'b0000000000010,
    PH_OPC     = 13'b0000000000100,
    PH_AHI     = 13'b0000000001000,
    PH_AMID    = 13'b0000000010000,
    PH_ALO     = 13'b0000000100000,
    PH_RDATA   = 13'b0000001000000,
    PH_WREN    = 13'b0000010000000,
    PH_STOP    = 13'b0000100000000,
    PH_STVAL   = 13'b0001000000000,
    PH_PDATA   = 13'b0010000000000,
    PH_POLLOP  = 13'b0100000000000,
    PH_POLLVAL = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       cs_start;
    logic       cs_end;
    logic       last;
  } res_t;

  function automatic res_t mk_spi(logic [7:0] data, logic cs_start, logic cs_end);
    res_t r;
    r.dest     = DEST_SPI;
    r.data     = data;
    r.cs_start = cs_start;
    r.cs_end   = cs_end;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_uart(logic [7:0] data);
    res_t r;
    r.dest     = DEST_UART;
    r.data     = data;
    r.cs_start = 1'b0;
    r.cs_end   = 1'b0;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/uart_spi_flash_programmer_unit.sv
// ----------------------------------------------------------------------------
// uart_spi_flash_programmer_unit - UART-driven SPI NOR flash sequencer
// Gathers 8-byte command frames from UART bytes and runs read, block erase,
// page fill and page program sequences as a stream of SPI / UART words.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                        | tuser      | tlast
//  s_axis   | in  | [7:0] data                   | kind       | -
//  m_axis   | out | [7:0] data_res, [8] cs_start,| dest       | last
//           |     | [9] cs_end, [15:10] zero     |            |
//
// One input word per cycle while m_axis keeps up. Each accepted word is decoded
// in the cycle it arrives and yields 0, 1 or 2 result words, pushed into a
// 4-deep result queue whose registered head drives m_axis. A read data reply
// yields two words, so a run of those drains slower than it arrives.
// s_axis_tready_o drops only while fewer than 2 slots are free.
// Page data comes from a simple dual-port page memory (fill writes at the
// counter, the read port runs at its next value), so the registered read
// holds the byte at the current counter value.
// Reset (async, active low) returns to idle, empties the queue and marks the
// page memory as unwritten (reads as zero until the first fill byte).
// Stalls on m_axis back up into the queue and then into s_axis.

module uart_spi_flash_programmer_unit #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data
  input  logic        s_axis_tuser_i,   // [0] kind
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_res, [8] cs_start, [9] cs_end
  output logic        m_axis_tuser_o,   // [0] dest
  output logic        m_axis_tlast_o
);

  import usfp_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_BYTES);  // page address bits
  localparam int unsigned CW = AW + 1;              // counter can hold PAGE_BYTES
  localparam logic [CW-1:0] PageLast = CW'(PAGE_BYTES - 1);
  localparam logic [CW-1:0] PageEnd  = CW'(PAGE_BYTES);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAW    = $clog2(QDepth);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  phase_e              phase_q, phase_d;
  logic [7:0]          frame_q [FrameBytes];
  logic [FrameIdxW-1:0] fidx_q, fidx_d;
  logic [CW-1:0]       bcnt_q, bcnt_d;
  logic [23:0]         rrem_q, rrem_d;
  logic                filled_q;

  // page memory
  logic [7:0]          page_mem [PAGE_BYTES];
  logic [7:0]          page_rd_q;
  logic [7:0]          page_byte;
  logic                mem_we;
  logic                frame_we;

  // result queue
  res_t                q_mem [QDepth];
  logic [QAW-1:0]      q_wptr_q, q_rptr_q;
  logic [QAW:0]        q_cnt_q;

  res_t                res0, res1;
  logic [1:0]          n_res;

  logic                s_hs, m_hs;
  logic                kind;
  logic [7:0]          din;
  logic [7:0]          op;
  logic [23:0]         fcount;
  logic [23:0]         rrem_dec;

  assign kind   = s_axis_tuser_i;
  assign din    = s_axis_tdata_i;
  assign op     = frame_q[0];
  assign fcount = {frame_q[1], frame_q[2], frame_q[3]};
  assign rrem_dec = rrem_q - 24'd1;

  assign s_axis_tready_o = (q_cnt_q <= (QAW+1)'(QDepth - 2));
  assign s_hs = s_axis_tvalid_i & s_axis_tready_o;
  assign m_hs = m_axis_tvalid_o & m_axis_tready_i;

  // unwritten page reads as zero
  assign page_byte = filled_q ? page_rd_q : 8'h00;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d  = phase_q;
    fidx_d   = fidx_q;
    bcnt_d   = bcnt_q;
    rrem_d   = rrem_q;
    mem_we   = 1'b0;
    frame_we = 1'b0;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;

    if (s_hs) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (kind == KIND_UART) begin
            frame_we = 1'b1;
            fidx_d   = fidx_q + 1'b1;
            if (fidx_q == FrameIdxW'(FrameBytes - 1)) begin
              // frame complete; byte 0 already stored
              if (op == OP_READ) begin
                res0 = mk_spi(CMD_READ, 1'b1, 1'b0); n_res = 2'd1;
                phase_d = PH_OPC;
              end else if (op == OP_FILL) begin
                res0 = mk_uart(OP_FILL); n_res = 2'd1;
                bcnt_d  = '0;
                phase_d = PH_FILL;
              end else if (op == OP_ERASE || op == OP_PROGRAM) begin
                res0 = mk_spi(CMD_WREN, 1'b1, 1'b1); n_res = 2'd1;
                phase_d = PH_WREN;
              end
              // 'd' and unknown opcodes: stay idle, no answer
            end
          end
        end

        PH_FILL: begin
          if (kind == KIND_UART) begin
            mem_we = 1'b1;
            if (bcnt_q == PageLast) begin
              bcnt_d  = '0;
              res0 = mk_uart(ANS_READY); n_res = 2'd1;
              phase_d = PH_IDLE;
            end else begin
              bcnt_d = bcnt_q + 1'b1;
            end
          end
        end

        PH_OPC: begin
          if (kind == KIND_SPI) begin
            res0 = mk_spi(frame_q[4], 1'b0, 1'b0); n_res = 2'd1;
            phase_d = PH_AHI;
          end
        end

        PH_AHI: begin
          if (kind == KIND_SPI) begin
            res0 = mk_spi(frame_q[5], 1'b0, 1'b0); n_res = 2'd1;
            phase_d = PH_AMID;
          end
        end

        PH_AMID: begin
          if (kind == KIND_SPI) begin
            // erase and zero-length read end the transaction on the last address byte
            res0 = mk_spi(frame_q[6], 1'b0,
                          (op == OP_READ) ? (fcount == 24'd0) : (op == OP_ERASE));
            n_res = 2'd1;
            phase_d = PH_ALO;
          end
        end

        PH_ALO: begin
          if (kind == KIND_SPI) begin
            if (op == OP_READ) begin
              rrem_d = fcount;
              n_res  = 2'd1;
              if (fcount == 24'd0) begin
                res0 = mk_uart(ANS_READY);
                phase_d = PH_IDLE;
              end else begin
                res0 = mk_spi(CMD_DUMMY, 1'b0, fcount == 24'd1);
                phase_d = PH_RDATA;
              end
            end else if (op == OP_ERASE) begin
              res0 = mk_spi(CMD_RDSR, 1'b1, 1'b0); n_res = 2'd1;
              phase_d = PH_POLLOP;
            end else begin
              // program: first page byte (counter sits at zero here)
              res0 = mk_spi(page_byte, 1'b0, PAGE_BYTES == 1); n_res = 2'd1;
              bcnt_d  = CW'(1);
              phase_d = PH_PDATA;
            end
          end
        end

        PH_RDATA: begin
          if (kind == KIND_SPI) begin
            res0   = mk_uart(din);
            rrem_d = rrem_dec;
            n_res  = 2'd2;
            if (rrem_dec == 24'd0) begin
              res1 = mk_uart(ANS_READY);
              phase_d = PH_IDLE;
            end else begin
              res1 = mk_spi(CMD_DUMMY, 1'b0, rrem_dec == 24'd1);
            end
          end
        end

        PH_WREN: begin
          if (kind == KIND_SPI) begin
            res0 = mk_spi(CMD_RDSR, 1'b1, 1'b0); n_res = 2'd1;
            phase_d = PH_STOP;
          end
        end

        PH_STOP: begin
          if (kind == KIND_SPI) begin
            res0 = mk_spi(CMD_DUMMY, 1'b0, 1'b1); n_res = 2'd1;
            phase_d = PH_STVAL;
          end
        end

        PH_STVAL: begin
          if (kind == KIND_SPI) begin
            n_res = 2'd1;
            if (!din[SR_WEL]) begin
              // write enable refused
              res0 = mk_uart(ANS_READY);
              phase_d = PH_IDLE;
            end else begin
              res0 = mk_spi((op == OP_ERASE) ? CMD_ERASE : CMD_PROG, 1'b1, 1'b0);
              phase_d = PH_OPC;
            end
          end
        end

        PH_PDATA: begin
          if (kind == KIND_SPI) begin
            n_res = 2'd1;
            if (bcnt_q < PageEnd) begin
              res0 = mk_spi(page_byte, 1'b0, bcnt_q == PageLast);
              bcnt_d = bcnt_q + 1'b1;
            end else begin
              bcnt_d = '0;
              res0 = mk_spi(CMD_RDSR, 1'b1, 1'b0);
              phase_d = PH_POLLOP;
            end
          end
        end

        PH_POLLOP: begin
          if (kind == KIND_SPI) begin
            res0 = mk_spi(CMD_DUMMY, 1'b0, 1'b1); n_res = 2'd1;
            phase_d = PH_POLLVAL;
          end
        end

        PH_POLLVAL: begin
          if (kind == KIND_SPI) begin
            n_res = 2'd1;
            if (din[SR_BUSY]) begin
              res0 = mk_spi(CMD_RDSR, 1'b1, 1'b0);
              phase_d = PH_POLLOP;
            end else begin
              res0 = mk_uart(ANS_READY);
              phase_d = PH_IDLE;
            end
          end
        end

        default: phase_d = PH_IDLE;
      endcase
    end

    // tag the final result of this word
    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      fidx_q   <= '0;
      bcnt_q   <= '0;
      rrem_q   <= '0;
      filled_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      bcnt_q  <= bcnt_d;
      rrem_q  <= rrem_d;
      if (mem_we) filled_q <= 1'b1;
    end
  end

  // frame bytes; stale contents are always overwritten before use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '{default: 8'h00};
    end else if (frame_we) begin
      frame_q[fidx_q] <= din;
    end
  end

  // --------------------------------------------------------------------------
  // Page memory: write during fill, read tracks the next counter value
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) page_mem[bcnt_q[AW-1:0]] <= din;
    page_rd_q <= page_mem[bcnt_d[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Result queue (up to two pushes, one pop per cycle)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) q_mem[q_wptr_q] <= res0;
    if (n_res == 2'd2) q_mem[q_wptr_q + 1'b1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q <= '0;
      q_rptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      q_wptr_q <= q_wptr_q + QAW'(n_res);
      if (m_hs) q_rptr_q <= q_rptr_q + 1'b1;
      q_cnt_q  <= q_cnt_q + (QAW+1)'(n_res) - (QAW+1)'(m_hs);
    end
  end

  res_t q_head;
  assign q_head = q_mem[q_rptr_q];

  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = {6'b000000, q_head.cs_end, q_head.cs_start, q_head.data};
  assign m_axis_tuser_o  = q_head.dest;
  assign m_axis_tlast_o  = q_head.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= (QAW+1)'(QDepth))
    else $error("result queue overflow");

  a_two_only_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res == 2'd2) |-> (phase_q == PH_RDATA))
    else $error("two results outside read data phase");

  a_fill_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && phase_q == PH_FILL && kind == KIND_UART) |=> filled_q)
    else $error("page not marked written after fill byte");

  a_fill_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FILL && n_res != 2'd0) |-> (res0.dest == DEST_UART && phase_d == PH_IDLE))
    else $error("unexpected result during fill");

endmodule

// File: tb/tb_uart_spi_flash_programmer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_spi_flash_programmer_unit - self-checking bench for the sequencer
// Feeds UART command frames and flash reply bytes, tracks the command state
// machine in a local model and checks every result word in order, with
// random idling on both streams, one long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_uart_spi_flash_programmer_unit;
  import usfp_pkg::*;

  localparam int unsigned PageBytes   = 256;
  localparam int unsigned PageAW      = $clog2(PageBytes);
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned RandomWords = 1050;
  localparam int unsigned TailWords   = 120;
  localparam int unsigned HoldCycles  = 400;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  uart_spi_flash_programmer_unit #(
    .PAGE_BYTES(PageBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the handshakes hang
  initial begin
    #10_000_000;
    $display("[uart_spi_flash_programmer_unit] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sequencer model state
  // --------------------------------------------------------------------------
  phase_e               sq_phase;
  logic [7:0]           frame_buf [FrameBytes];
  logic [FrameIdxW-1:0] frame_idx;
  logic [7:0]           page_mem  [PageBytes];
  int unsigned          page_idx;
  logic [23:0]          reads_left;

  res_t        pending_words[$];   // result words still owed by the DUT
  int unsigned words_in, words_out, fail_count;
  int unsigned n_read, n_erase, n_prog, n_fill, n_other, n_refused, n_busy_polls;

  bit          src_gaps, sink_gaps;
  int unsigned hold_req;           // long output stall, picked up by the sink

  function automatic res_t spi_word(logic [7:0] d, logic cs_s, logic cs_e);
    res_t r;
    r.dest     = DEST_SPI;
    r.data     = d;
    r.cs_start = cs_s;
    r.cs_end   = cs_e;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic res_t uart_word(logic [7:0] d);
    res_t r;
    r.dest     = DEST_UART;
    r.data     = d;
    r.cs_start = 1'b0;
    r.cs_end   = 1'b0;
    r.last     = 1'b0;
    return r;
  endfunction

  // Advance the model by one accepted word and queue the words it owes.
  // Returns 0 for words the block drops or ignores.
  function automatic bit sequencer_step(logic kind, logic [7:0] d);
    res_t        words[$];
    logic [7:0]  op;
    logic [23:0] cnt;
    logic        ce;
    bit          took;
    op   = frame_buf[0];
    cnt  = {frame_buf[1], frame_buf[2], frame_buf[3]};
    took = 1'b1;
    if (sq_phase == PH_IDLE) begin
      if (kind == KIND_UART) begin
        frame_buf[frame_idx] = d;
        frame_idx = frame_idx + 1'b1;
        if (frame_idx == '0) begin
          op = frame_buf[0];
          if (op == OP_READ) begin
            n_read++;
            words.push_back(spi_word(CMD_READ, 1'b1, 1'b0));
            sq_phase = PH_OPC;
          end else if (op == OP_FILL) begin
            n_fill++;
            words.push_back(uart_word(OP_FILL));
            page_idx = 0;
            sq_phase = PH_FILL;
          end else if (op == OP_ERASE || op == OP_PROGRAM) begin
            if (op == OP_ERASE) n_erase++;
            else n_prog++;
            words.push_back(spi_word(CMD_WREN, 1'b1, 1'b1));
            sq_phase = PH_WREN;
          end else begin
            // done or unknown opcode: frame eaten, no answer
            n_other++;
          end
        end
      end else begin
        took = 1'b0;
      end
    end else if (sq_phase == PH_FILL) begin
      if (kind == KIND_UART) begin
        page_mem[PageAW'(page_idx)] = d;
        page_idx++;
        if (page_idx >= PageBytes) begin
          page_idx = 0;
          words.push_back(uart_word(ANS_READY));
          sq_phase = PH_IDLE;
        end
      end else begin
        took = 1'b0;
      end
    end else if (kind == KIND_UART) begin
      took = 1'b0;   // UART byte while a flash sequence runs
    end else begin
      case (sq_phase)
        PH_OPC: begin
          words.push_back(spi_word(frame_buf[4], 1'b0, 1'b0));
          sq_phase = PH_AHI;
        end
        PH_AHI: begin
          words.push_back(spi_word(frame_buf[5], 1'b0, 1'b0));
          sq_phase = PH_AMID;
        end
        PH_AMID: begin
          // erase ends on the address; a zero-length read does too
          ce = (op == OP_READ) ? (cnt == '0) : (op == OP_ERASE);
          words.push_back(spi_word(frame_buf[6], 1'b0, ce));
          sq_phase = PH_ALO;
        end
        PH_ALO: begin
          if (op == OP_READ) begin
            reads_left = cnt;
            if (reads_left == '0) begin
              words.push_back(uart_word(ANS_READY));
              sq_phase = PH_IDLE;
            end else begin
              words.push_back(spi_word(CMD_DUMMY, 1'b0, reads_left == 24'd1));
              sq_phase = PH_RDATA;
            end
          end else if (op == OP_ERASE) begin
            words.push_back(spi_word(CMD_RDSR, 1'b1, 1'b0));
            sq_phase = PH_POLLOP;
          end else begin
            words.push_back(spi_word(page_mem[0], 1'b0, PageBytes == 1));
            page_idx = 1;
            sq_phase = PH_PDATA;
          end
        end
        PH_RDATA: begin
          words.push_back(uart_word(d));
          reads_left = reads_left - 1'b1;
          if (reads_left == '0) begin
            words.push_back(uart_word(ANS_READY));
            sq_phase = PH_IDLE;
          end else begin
            words.push_back(spi_word(CMD_DUMMY, 1'b0, reads_left == 24'd1));
          end
        end
        PH_WREN: begin
          words.push_back(spi_word(CMD_RDSR, 1'b1, 1'b0));
          sq_phase = PH_STOP;
        end
        PH_STOP: begin
          words.push_back(spi_word(CMD_DUMMY, 1'b0, 1'b1));
          sq_phase = PH_STVAL;
        end
        PH_STVAL: begin
          if (!d[SR_WEL]) begin
            n_refused++;
            words.push_back(uart_word(ANS_READY));
            sq_phase = PH_IDLE;
          end else begin
            words.push_back(spi_word((op == OP_ERASE) ? CMD_ERASE : CMD_PROG, 1'b1, 1'b0));
            sq_phase = PH_OPC;
          end
        end
        PH_PDATA: begin
          if (page_idx < PageBytes) begin
            words.push_back(spi_word(page_mem[PageAW'(page_idx)], 1'b0,
                                     page_idx == PageBytes - 1));
            page_idx++;
          end else begin
            page_idx = 0;
            words.push_back(spi_word(CMD_RDSR, 1'b1, 1'b0));
            sq_phase = PH_POLLOP;
          end
        end
        PH_POLLOP: begin
          words.push_back(spi_word(CMD_DUMMY, 1'b0, 1'b1));
          sq_phase = PH_POLLVAL;
        end
        PH_POLLVAL: begin
          if (d[SR_BUSY]) begin
            n_busy_polls++;
            words.push_back(spi_word(CMD_RDSR, 1'b1, 1'b0));
            sq_phase = PH_POLLOP;
          end else begin
            words.push_back(uart_word(ANS_READY));
            sq_phase = PH_IDLE;
          end
        end
        default: sq_phase = PH_IDLE;
      endcase
    end
    if (words.size() != 0) words[words.size() - 1].last = 1'b1;
    foreach (words[i]) pending_words.push_back(words[i]);
    return took;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= ReportMax) $display("FAIL: %s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // output side: random stalls, long hold-off on request, in-order check
  // --------------------------------------------------------------------------
  int unsigned hold_left, stall_left;

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.dest     = m_axis_tuser_o;
      got.data     = m_axis_tdata_o[7:0];
      got.cs_start = m_axis_tdata_o[8];
      got.cs_end   = m_axis_tdata_o[9];
      got.last     = m_axis_tlast_o;
      words_out++;
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected word %0d: dest=%0d data=%02h", words_out,
                               got.dest, got.data));
      end else begin
        want = pending_words.pop_front();
        if (got.dest !== want.dest || got.data !== want.data ||
            got.cs_start !== want.cs_start || got.cs_end !== want.cs_end ||
            got.last !== want.last)
          note_failure($sformatf(
            "word %0d exp dest=%0d data=%02h cs=%0d/%0d last=%0d, got %0d %02h %0d/%0d %0d",
            words_out, want.dest, want.data, want.cs_start, want.cs_end, want.last,
            got.dest, got.data, got.cs_start, got.cs_end, got.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // valid stays high from word to word; it only drops at the start of a gap or in wait_drain
  task automatic send_word(input logic kind, input logic [7:0] d);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (sequencer_step(kind, d)) words_in++;
  endtask

  task automatic send_frame(input logic [7:0] op, input logic [23:0] cnt,
                            input logic [23:0] addr, input logic [7:0] tail);
    send_word(KIND_UART, op);
    send_word(KIND_UART, cnt[23:16]);
    send_word(KIND_UART, cnt[15:8]);
    send_word(KIND_UART, cnt[7:0]);
    send_word(KIND_UART, addr[23:16]);
    send_word(KIND_UART, addr[15:8]);
    send_word(KIND_UART, addr[7:0]);
    send_word(KIND_UART, tail);
  endtask

  // Play the flash side (or the page upload) until the command is over.
  // chatter mixes in words the block has to drop.
  task automatic complete_command(input bit wel_ok, input int unsigned polls,
                                  input bit chatter);
    logic [7:0] d;
    if (sq_phase == PH_FILL) begin
      repeat (PageBytes) begin
        if (chatter && $urandom_range(0, 15) == 0) send_word(KIND_SPI, 8'($urandom()));
        send_word(KIND_UART, 8'($urandom()));
      end
    end
    while (sq_phase != PH_IDLE && sq_phase != PH_FILL) begin
      d = 8'($urandom());
      if (sq_phase == PH_STVAL) d[SR_WEL] = wel_ok;
      if (sq_phase == PH_POLLVAL) begin
        d[SR_BUSY] = (polls != 0);
        if (polls != 0) polls--;
      end
      if (chatter && $urandom_range(0, 15) == 0) send_word(KIND_UART, 8'($urandom()));
      send_word(KIND_SPI, d);
    end
  endtask

  // sender holds off until the DUT has delivered everything owed
  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic random_session();
    int unsigned pick;
    bit          chatter;
    logic [7:0]  op;
    logic [23:0] cnt;
    pick    = $urandom_range(0, 99);
    chatter = ($urandom_range(0, 3) == 0);
    cnt     = 24'($urandom());
    if (pick < 30) begin
      op  = OP_READ;
      cnt = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 300))
                                        : 24'($urandom_range(0, 12));
    end else if (pick < 50) begin
      op = OP_ERASE;
    end else if (pick < 58) begin
      op = OP_PROGRAM;
    end else if (pick < 66) begin
      op = OP_FILL;
    end else if (pick < 74) begin
      op = OP_DONE;
    end else if (pick < 86) begin
      // any opcode at all; keep an accidental read short
      op = 8'($urandom());
      if (op == OP_READ) cnt = 24'($urandom_range(0, 12));
    end else begin
      // stray replies while idle
      repeat ($urandom_range(1, 4)) send_word(KIND_SPI, 8'($urandom()));
      return;
    end
    send_frame(op, cnt, 24'($urandom()), 8'($urandom()));
    complete_command($urandom_range(0, 4) != 0, $urandom_range(0, 3), chatter);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // stray reply, zero-length read at the top address, refused erase with a
  // UART byte arriving mid-sequence
  task automatic test_directed();
    send_word(KIND_SPI, 8'hFF);
    send_frame(OP_READ, 24'h000000, 24'hFFFFFF, 8'hFF);
    send_word(KIND_SPI, 8'hFF);
    send_word(KIND_SPI, 8'h00);
    send_word(KIND_SPI, 8'hFF);
    send_word(KIND_SPI, 8'h00);
    send_frame(OP_ERASE, 24'hFFFFFF, 24'h000000, 8'h00);
    send_word(KIND_UART, OP_READ);
    send_word(KIND_SPI, 8'h00);
    send_word(KIND_SPI, 8'hFF);
    send_word(KIND_SPI, 8'hFD);   // every status bit but write-enable
    wait_drain();
  endtask

  // program before any fill: the page must come out as zeros
  task automatic test_blank_page_program();
    send_frame(OP_PROGRAM, 24'($urandom()), 24'($urandom()), 8'($urandom()));
    complete_command(1'b1, 2, 1'b0);
    wait_drain();
  endtask

  // output held off for a long time while a read keeps feeding replies,
  // so the result queue fills and the input side has to back off
  task automatic test_stalled_read();
    hold_req = HoldCycles;
    send_frame(OP_READ, 24'd60, 24'($urandom()), 8'($urandom()));
    complete_command(1'b1, 0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_sessions();
    int unsigned target;
    target = words_in + RandomWords;
    while (words_in < target) random_session();
    wait_drain();
  endtask

  // closing stretch with both streams running flat out
  task automatic test_unpaced_tail();
    int unsigned target;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    target    = words_in + TailWords;
    while (words_in < target) random_session();
    wait_drain();
  endtask

  initial begin : run
    sq_phase   = PH_IDLE;
    frame_idx  = '0;
    page_idx   = 0;
    reads_left = '0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    foreach (page_mem[i]) page_mem[i] = '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_blank_page_program();
    test_stalled_read();
    test_random_sessions();
    test_unpaced_tail();

    repeat (TailCycles) @(posedge clk_i);
    if (pending_words.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", pending_words.size()));

    $display("run: %0d words in, %0d words out; frames: %0d read, %0d erase, %0d program,",
             words_in, words_out, n_read, n_erase, n_prog);
    $display("     %0d fill, %0d done/unknown; %0d write-enable refusals, %0d busy polls",
             n_fill, n_other, n_refused, n_busy_polls);
    if (fail_count == 0) begin
      $display("[uart_spi_flash_programmer_unit] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[uart_spi_flash_programmer_unit] ERROR");
    end
    $finish;
  end

endmodule
